### sv/btm_pkg.sv
// Shared types and constants of the burst temporal merge block.
`default_nettype none
package btm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int FI_W        = 3;
    localparam int NF_W        = 4;
    localparam int WGT_W       = 3;
    localparam int DIFF_W      = 24;
    localparam int PIX_W       = 23;
    localparam int WSUM_W      = 6;
    localparam int TOTAL_W     = NF_W + 3;
    localparam int PROD_W      = SAMPLE_W + TOTAL_W;
    localparam int MSUM_W      = PIX_W + 1;
    localparam int DIVD_W      = MSUM_W - 3;
    localparam int CNT_W       = $clog2(DIVD_W + 1);
    localparam int DIFF_SHIFT  = 15;
    localparam int DQ_W        = DIFF_W - DIFF_SHIFT;

    localparam logic [DIFF_W-1:0] DIFF_MAX    = {DIFF_W{1'b1}};
    localparam logic [PIX_W-1:0]  PIX_MAX     = {PIX_W{1'b1}};
    localparam logic [WSUM_W-1:0] WSUM_MAX    = {WSUM_W{1'b1}};
    localparam logic [NF_W-1:0]   WEIGHT_FULL = 4'd8;
    localparam logic [NF_W-1:0]   NF_RESET    = 4'd1;

    typedef enum logic {
        OP_WEIGHT = 1'b0,
        OP_MERGE  = 1'b1
    } t_opcode;

    typedef enum logic {
        KIND_WEIGHT = 1'b0,
        KIND_PIXEL  = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_SUM,
        S_DIV
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [NF_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

### sv/btm_weight_ram.sv
// Per-frame weight memory, one write and one registered read port.
`default_nettype none
module btm_weight_ram #(
    parameter int DEPTH = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [btm_pkg::WGT_W-1:0]  i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [btm_pkg::WGT_W-1:0]  o_rdata
);
    import btm_pkg::*;

    logic [WGT_W-1:0] r_mem [0:DEPTH-1];
    logic [WGT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### sv/btm_divider.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module btm_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire btm_pkg::t_div_req i_req,
    output btm_pkg::t_div_rsp      o_rsp
);
    import btm_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVD_W-1:0] r_quo;
    logic [NF_W-1:0]   r_rem;
    logic [NF_W-1:0]   r_div;
    logic [NF_W:0]     s_shift;
    logic [NF_W:0]     s_sub;
    logic              s_ge;

    always_comb begin
        s_shift = {r_rem, r_quo[DIVD_W-1]};
        s_ge    = s_shift >= {1'b0, r_div};
        s_sub   = s_shift - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIVD_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= s_ge ? s_sub[NF_W-1:0] : s_shift[NF_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], s_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
`default_nettype wire

### sv/burst_temporal_merge.sv
// Top level of the burst temporal merge: control, accumulators, output register.
//
// channel   direction  handshake                 payload
// -------   ---------  ------------------------  ----------------------------------------
// in        input      i_in_valid / o_in_stall    opcode, frame_index, ref/alt_sample, last
// out       output     o_out_valid / i_out_stall  result_kind, result_value
// cfg       input      i_cfg_valid / o_cfg_ready  num_frames
//
// Steps: a weight transaction or a non-last merge transaction is accepted (with the
//   weight memory read), then accumulated. A last merge transaction then goes on to
//   multiply, sum and divide, 21 quotient bits at one per cycle, then loads the result.
// Reset: synchronous, active low; clears accumulators, num_frames to 1, control state.
//   The weight memory is not cleared.
// Stalls: a finished result sits in the output register while the next transaction
//   is accepted; the block only waits when a new result meets a full, stalled register.
`default_nettype none
module burst_temporal_merge #(
    parameter int MAX_FRAMES = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_opcode,
    input  wire logic [btm_pkg::FI_W-1:0]      i_frame_index,
    input  wire logic [btm_pkg::SAMPLE_W-1:0]  i_ref_sample,
    input  wire logic [btm_pkg::SAMPLE_W-1:0]  i_alt_sample,
    input  wire logic                          i_last,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_result_kind,
    output logic      [btm_pkg::SAMPLE_W-1:0]  o_result_value,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [btm_pkg::NF_W-1:0]      i_cfg_num_frames
);
    import btm_pkg::*;

    localparam int AW = $clog2(MAX_FRAMES);

    // state and registers
    t_state              r_state, n_state;
    logic [NF_W-1:0]     r_num_frames;
    logic [DIFF_W-1:0]   r_diff_acc;
    logic [PIX_W-1:0]    r_pix_acc;
    logic [WSUM_W-1:0]   r_wgt_acc;
    logic                r_op;
    logic [FI_W-1:0]     r_fi;
    logic [SAMPLE_W-1:0] r_ref;
    logic [SAMPLE_W-1:0] r_alt;
    logic                r_last;
    logic                r_in_range;
    logic [PROD_W-1:0]   r_prod;
    logic                r_out_valid;
    logic                r_out_kind;
    logic [SAMPLE_W-1:0] r_out_value;

    // control strobes
    logic s_accept;
    logic s_out_free;
    logic s_exec_fire;
    logic s_wgt_emit;
    logic s_pix_emit;
    logic s_mem_we;
    logic s_mul_fire;
    logic s_sum_fire;

    // datapath
    logic [WGT_W-1:0]    s_rdata;
    logic [WGT_W-1:0]    s_w;
    logic [DIFF_W:0]     s_diff_raw;
    logic [DIFF_W-1:0]   s_diff_sum;
    logic [SAMPLE_W-1:0] s_ad;
    logic [DQ_W-1:0]     s_dq;
    logic [NF_W-1:0]     s_d;
    logic [WGT_W-1:0]    s_weight;
    logic [PIX_W:0]      s_pix_raw;
    logic [PIX_W-1:0]    s_pix_sum;
    logic [WSUM_W:0]     s_wsum_raw;
    logic [WSUM_W-1:0]   s_wsum;
    logic [NF_W-1:0]     s_nf;
    logic [TOTAL_W-1:0]  s_total;
    logic [TOTAL_W-1:0]  s_refw;
    logic [MSUM_W-1:0]   s_msum;
    logic [SAMPLE_W-1:0] s_pix_out;
    t_div_req            s_div_req;
    t_div_rsp            s_div_rsp;

    assign o_cfg_ready = 1'b1;
    assign s_out_free  = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (r_op == OP_MERGE) begin
                    n_state = r_last ? S_MUL : S_IDLE;
                end else if (!r_last || s_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_MUL:  n_state = S_SUM;
            S_SUM:  n_state = S_DIV;
            S_DIV: begin
                if (s_div_rsp.done && s_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall  = 1'b1;
        s_exec_fire = 1'b0;
        s_mul_fire  = 1'b0;
        s_sum_fire  = 1'b0;
        s_pix_emit  = 1'b0;
        case (r_state)
            S_IDLE: o_in_stall = 1'b0;
            S_EXEC: s_exec_fire = (r_op == OP_MERGE) || !r_last || s_out_free;
            S_MUL:  s_mul_fire = 1'b1;
            S_SUM:  s_sum_fire = 1'b1;
            S_DIV:  s_pix_emit = s_div_rsp.done && s_out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    assign s_accept   = i_in_valid && !o_in_stall;
    assign s_wgt_emit = s_exec_fire && (r_op == OP_WEIGHT) && r_last;
    assign s_mem_we   = s_wgt_emit && r_in_range;

    // weight path: saturating |ref - alt| sum, then 8 - clamp(sum >> 15, 1, 8)
    always_comb begin
        s_ad       = (r_ref > r_alt) ? (r_ref - r_alt) : (r_alt - r_ref);
        s_diff_raw = {1'b0, r_diff_acc} + (DIFF_W + 1)'(s_ad);
        s_diff_sum = s_diff_raw[DIFF_W] ? DIFF_MAX : s_diff_raw[DIFF_W-1:0];
        s_dq       = s_diff_sum[DIFF_W-1:DIFF_SHIFT];
        if (s_dq == '0) begin
            s_d = NF_W'(1);
        end else if (s_dq > DQ_W'(WEIGHT_FULL)) begin
            s_d = WEIGHT_FULL;
        end else begin
            s_d = s_dq[NF_W-1:0];
        end
        s_weight = WGT_W'(WEIGHT_FULL - s_d);
    end

    // merge path: reference-only items and out-of-range frames add nothing
    always_comb begin
        s_w        = (r_in_range && (r_fi != '0)) ? s_rdata : '0;
        s_pix_raw  = {1'b0, r_pix_acc} + ((PIX_W + 1)'(r_alt) * (PIX_W + 1)'(s_w));
        s_pix_sum  = s_pix_raw[PIX_W] ? PIX_MAX : s_pix_raw[PIX_W-1:0];
        s_wsum_raw = {1'b0, r_wgt_acc} + (WSUM_W + 1)'(s_w);
        s_wsum     = s_wsum_raw[WSUM_W] ? WSUM_MAX : s_wsum_raw[WSUM_W-1:0];
    end

    // total weight 8*nf; the reference takes what the alternates left over
    always_comb begin
        if (r_num_frames == '0) begin
            s_nf = NF_W'(1);
        end else if (32'(r_num_frames) > MAX_FRAMES) begin
            s_nf = NF_W'(MAX_FRAMES);
        end else begin
            s_nf = r_num_frames;
        end
        s_total = {s_nf, 3'b000};
        s_refw  = (TOTAL_W'(r_wgt_acc) > s_total) ? '0 : (s_total - TOTAL_W'(r_wgt_acc));
        s_msum  = {1'b0, r_pix_acc} + MSUM_W'(r_prod);
    end

    // divide by 8 is a shift; the remaining divide by nf goes to the serial divider
    assign s_div_req.start    = s_sum_fire;
    assign s_div_req.dividend = s_msum[MSUM_W-1:3];
    assign s_div_req.divisor  = s_nf;

    assign s_pix_out = (|s_div_rsp.quotient[DIVD_W-1:SAMPLE_W]) ?
                       {SAMPLE_W{1'b1}} : s_div_rsp.quotient[SAMPLE_W-1:0];

    btm_weight_ram #(
        .DEPTH (MAX_FRAMES)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (s_mem_we),
        .i_waddr (AW'(r_fi)),
        .i_wdata (s_weight),
        .i_re    (s_accept && (32'(i_frame_index) < MAX_FRAMES)),
        .i_raddr (AW'(i_frame_index)),
        .o_rdata (s_rdata)
    );

    btm_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_div_req),
        .o_rsp   (s_div_rsp)
    );

    // control and accumulator registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_num_frames <= NF_RESET;
            r_diff_acc   <= '0;
            r_pix_acc    <= '0;
            r_wgt_acc    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_num_frames <= i_cfg_num_frames;
            end
            if (s_exec_fire && (r_op == OP_WEIGHT)) begin
                r_diff_acc <= r_last ? '0 : s_diff_sum;
            end
            if (s_exec_fire && (r_op == OP_MERGE)) begin
                r_pix_acc <= s_pix_sum;
                r_wgt_acc <= s_wsum;
            end else if (s_sum_fire) begin
                r_pix_acc <= '0;
                r_wgt_acc <= '0;
            end
            if (s_wgt_emit || s_pix_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op       <= i_opcode;
            r_fi       <= i_frame_index;
            r_ref      <= i_ref_sample;
            r_alt      <= i_alt_sample;
            r_last     <= i_last;
            r_in_range <= 32'(i_frame_index) < MAX_FRAMES;
        end
        if (s_mul_fire) begin
            r_prod <= PROD_W'(r_ref) * PROD_W'(s_refw);
        end
        if (s_wgt_emit) begin
            r_out_kind  <= KIND_WEIGHT;
            r_out_value <= SAMPLE_W'(s_weight);
        end else if (s_pix_emit) begin
            r_out_kind  <= KIND_PIXEL;
            r_out_value <= s_pix_out;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_result_value = r_out_value;

    // an accepted transaction always goes to the execute step next
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == S_EXEC))
        else $error("accepted transaction did not reach execute");

    // merge accumulators are clear while the division runs
    a_div_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ((r_pix_acc == '0) && (r_wgt_acc == '0)))
        else $error("merge accumulators not cleared before divide");

    // a tile weight result clears the difference sum
    a_diff_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_wgt_emit |=> (r_diff_acc == '0))
        else $error("difference sum not cleared after weight");

    // a weight result is at most seven
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_WEIGHT)) |-> (r_out_value <= SAMPLE_W'(7)))
        else $error("weight result out of range");

    // results are only loaded into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_wgt_emit || s_pix_emit) |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");

endmodule
`default_nettype wire

### tb/sv/burst_temporal_merge_checker.sv
// Checker for the burst temporal merge: predicts each result and compares it on the output.
`timescale 1ns / 1ps
module burst_temporal_merge_checker #(
    parameter int MAX_FRAMES = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic                         i_opcode,
    input  logic [btm_pkg::FI_W-1:0]     i_frame_index,
    input  logic [btm_pkg::SAMPLE_W-1:0] i_ref_sample,
    input  logic [btm_pkg::SAMPLE_W-1:0] i_alt_sample,
    input  logic                         i_last,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic                         i_result_kind,
    input  logic [btm_pkg::SAMPLE_W-1:0] i_result_value,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [btm_pkg::NF_W-1:0]     i_cfg_num_frames,
    output int                           o_fail_count,
    output int                           o_pending
);
    import btm_pkg::*;

    typedef struct packed {
        t_kind               kind;
        logic [SAMPLE_W-1:0] value;
    } t_merge_result;

    // shadow of the block state
    logic [DIFF_W-1:0] diff_sum;
    logic [WGT_W-1:0]  tile_weight [MAX_FRAMES];
    logic [PIX_W-1:0]  pixel_sum;
    logic [WSUM_W-1:0] weight_sum;
    logic [NF_W-1:0]   frames_cfg;

    t_merge_result awaited_results [$];
    int            mismatches = 0;

    initial o_fail_count = 0;
    initial o_pending = 0;

    // Advances the shadow state by one transaction; returns 1 when a result is due.
    function automatic bit fold_sample(input logic op, input logic [FI_W-1:0] fi,
                                       input logic [SAMPLE_W-1:0] ref_s,
                                       input logic [SAMPLE_W-1:0] alt_s,
                                       input logic lst, output t_merge_result res);
        logic [SAMPLE_W-1:0] lum_diff;
        logic [DIFF_W:0]     dsum;
        int unsigned         dq, wt, nf, total, refw, psum, wsum, quot;
        begin
            res = '0;
            if (op == OP_WEIGHT) begin
                lum_diff = (ref_s > alt_s) ? ref_s - alt_s : alt_s - ref_s;
                dsum = diff_sum + lum_diff;
                diff_sum = (dsum > DIFF_MAX) ? DIFF_MAX : dsum[DIFF_W-1:0];
                if (!lst) return 1'b0;
                dq = diff_sum >> DIFF_SHIFT;
                if (dq < 1) dq = 1;
                if (dq > WEIGHT_FULL) dq = WEIGHT_FULL;
                wt = WEIGHT_FULL - dq;
                if (fi < MAX_FRAMES) tile_weight[fi] = wt[WGT_W-1:0];
                diff_sum = '0;
                res.kind = KIND_WEIGHT;
                res.value = wt[SAMPLE_W-1:0];
                return 1'b1;
            end
            if (fi != 0) begin
                wt = (fi < MAX_FRAMES) ? tile_weight[fi] : 0;
                psum = pixel_sum + alt_s * wt;
                pixel_sum = (psum > PIX_MAX) ? PIX_MAX : psum[PIX_W-1:0];
                wsum = weight_sum + wt;
                weight_sum = (wsum > WSUM_MAX) ? WSUM_MAX : wsum[WSUM_W-1:0];
            end
            if (!lst) return 1'b0;
            nf = frames_cfg;
            if (nf < 1) nf = 1;
            if (nf > MAX_FRAMES) nf = MAX_FRAMES;
            total = WEIGHT_FULL * nf;
            refw = (weight_sum > total) ? 0 : total - weight_sum;
            quot = (pixel_sum + ref_s * refw) / total;
            if (quot > 16'hFFFF) quot = 16'hFFFF;
            pixel_sum = '0;
            weight_sum = '0;
            res.kind = KIND_PIXEL;
            res.value = quot[SAMPLE_W-1:0];
            return 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_merge_result want, got;
        if (!i_rst_n) begin
            diff_sum = '0;
            pixel_sum = '0;
            weight_sum = '0;
            frames_cfg = NF_RESET;
            awaited_results.delete();
        end else begin
            // a result leaving now can't come from a transaction accepted now
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result kind=%0d value=%0d", $realtime,
                                 i_result_kind, i_result_value);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_result_kind !== want.kind || i_result_value !== want.value) begin
                        if (mismatches < 10)
                            $display("%0t: mismatch kind exp=%0d got=%0d value exp=%0d got=%0d",
                                     $realtime, want.kind, i_result_kind, want.value,
                                     i_result_value);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                frames_cfg = i_cfg_num_frames;
            if (i_in_valid && !i_in_stall) begin
                if (fold_sample(i_opcode, i_frame_index, i_ref_sample, i_alt_sample,
                                i_last, got))
                    awaited_results.push_back(got);
            end
        end
        o_pending <= awaited_results.size();
        o_fail_count <= mismatches;
    end

endmodule

### tb/sv/burst_temporal_merge_test.sv
// Top of the burst temporal merge testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module burst_temporal_merge_test;
    import btm_pkg::*;

    localparam int MAX_FRAMES  = 8;
    localparam int HOLD_CYCLES = 400;  // long receiver hold-off, fills the block
    localparam int SETTLE      = 32;   // settle margin after the checker reports nothing pending
    localparam int PHASE_ITEMS = 90;   // 8 phases -> about 1000 transactions with directed

    // ---------------------------------------------------------------------
    // DUT-side signals; every input is known from time zero
    // ---------------------------------------------------------------------
    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_in_valid       = 1'b0;
    t_opcode             i_opcode         = OP_WEIGHT;
    logic [FI_W-1:0]     i_frame_index    = '0;
    logic [SAMPLE_W-1:0] i_ref_sample     = '0;
    logic [SAMPLE_W-1:0] i_alt_sample     = '0;
    logic                i_last           = 1'b0;
    logic                i_out_stall      = 1'b0;
    logic                i_cfg_valid      = 1'b0;
    logic [NF_W-1:0]     i_cfg_num_frames = NF_RESET;
    logic                o_in_stall;
    logic                o_out_valid;
    logic                o_result_kind;
    logic [SAMPLE_W-1:0] o_result_value;
    logic                o_cfg_ready;

    int fail_count;
    int pending;

    // stimulus bookkeeping
    int sent_items = 0;
    int tx_calm    = 0;
    int rx_calm    = 0;
    int hold_req   = 0;   // bumped by the stimulus to ask the receiver for a long hold
    int hold_done  = 0;

    always #2 i_clk = ~i_clk;

    burst_temporal_merge #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_frame_index    (i_frame_index),
        .i_ref_sample     (i_ref_sample),
        .i_alt_sample     (i_alt_sample),
        .i_last           (i_last),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result_kind    (o_result_kind),
        .o_result_value   (o_result_value),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_num_frames (i_cfg_num_frames)
    );

    burst_temporal_merge_checker #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_frame_index    (i_frame_index),
        .i_ref_sample     (i_ref_sample),
        .i_alt_sample     (i_alt_sample),
        .i_last           (i_last),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_result_kind    (o_result_kind),
        .i_result_value   (o_result_value),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_num_frames (i_cfg_num_frames),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // Random idle gap before the next transaction or result, with runs of
    // back-to-back transfers so both busy and gappy traffic show up.
    function automatic int draw_gap(inout int calm);
        begin
            if (calm > 0) begin
                calm--;
                return 0;
            end
            if ($urandom_range(0, 31) == 0) begin
                calm = $urandom_range(10, 40);
                return 0;
            end
            return $urandom_range(0, 15);
        end
    endfunction

    // One input transaction. Valid stays high after acceptance so the next
    // call can follow back to back; it only drops when a gap is drawn.
    task automatic send_item(input t_opcode op, input logic [FI_W-1:0] fi,
                             input logic [SAMPLE_W-1:0] ref_s,
                             input logic [SAMPLE_W-1:0] alt_s, input logic lst);
        int gap;
        begin
            gap = draw_gap(tx_calm);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid    <= 1'b1;
            i_opcode      <= op;
            i_frame_index <= fi;
            i_ref_sample  <= ref_s;
            i_alt_sample  <= alt_s;
            i_last        <= lst;
            do @(posedge i_clk); while (o_in_stall);
            sent_items++;
        end
    endtask

    // A tile of identical luma pairs, last mark on the final one.
    task automatic weight_tile(input logic [FI_W-1:0] fi, input logic [SAMPLE_W-1:0] ref_s,
                               input logic [SAMPLE_W-1:0] alt_s, input int pairs);
        begin
            for (int p = 0; p < pairs; p++)
                send_item(OP_WEIGHT, fi, ref_s, alt_s, p == pairs - 1);
        end
    endtask

    // Sender pause: nothing in flight and nothing owed. The first edge lets the
    // checker's pending count catch the last accepted transaction.
    task automatic wait_drained;
        begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while (pending != 0) @(posedge i_clk);
            repeat (SETTLE) @(posedge i_clk);
        end
    endtask

    // num_frames write, only ever done with the block idle
    task automatic write_frames(input logic [NF_W-1:0] nf);
        begin
            wait_drained();
            i_cfg_valid      <= 1'b1;
            i_cfg_num_frames <= nf;
            do @(posedge i_clk); while (!o_cfg_ready);
            i_cfg_valid <= 1'b0;
        end
    endtask

    // Mostly well-formed tiles and pixel bursts with random content, some noise.
    // All frame weights are written before this runs, so any frame index is legal.
    task automatic random_traffic(input int n_items);
        int                  start, pick, len, k;
        logic [FI_W-1:0]     fi_t;
        logic [SAMPLE_W-1:0] ref_s, mask;
        begin
            start = sent_items;
            while (sent_items - start < n_items) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    // noise: any field, may break a sequence in progress
                    send_item(t_opcode'($urandom_range(0, 1)), FI_W'($urandom_range(0, 7)),
                              SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                              1'($urandom_range(0, 1)));
                end else if (pick <= 3) begin
                    // luma tile; diff magnitude picked so all weights 0..7 occur
                    len  = ($urandom_range(0, 49) == 0) ? 256 : $urandom_range(1, 16);
                    k    = $urandom_range(0, 16);
                    mask = SAMPLE_W'((32'd1 << k) - 1);
                    fi_t = FI_W'($urandom_range(0, 7));
                    for (int p = 0; p < len; p++) begin
                        ref_s = SAMPLE_W'($urandom);
                        send_item(OP_WEIGHT,
                                  (p == len - 1) ? fi_t : FI_W'($urandom_range(0, 7)),
                                  ref_s, ref_s ^ (SAMPLE_W'($urandom) & mask),
                                  p == len - 1);
                    end
                end else begin
                    // one output pixel across a handful of frames
                    len = $urandom_range(1, 9);
                    for (int p = 0; p < len; p++)
                        send_item(OP_MERGE, FI_W'($urandom_range(0, 7)), SAMPLE_W'($urandom),
                                  SAMPLE_W'($urandom), p == len - 1);
                end
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Receiver: random stall per result, plus the long hold when asked
    // ---------------------------------------------------------------------
    initial begin : receiver
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req != hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done++;
            end else begin
                gap = draw_gap(rx_calm);
                if (gap > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            // leave the wait on a result or on a new hold request
            do @(posedge i_clk); while (!o_out_valid && hold_req == hold_done);
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus and verdict
    // ---------------------------------------------------------------------
    initial begin : stimulus
        logic [NF_W-1:0] nf_plan [6];
        logic [NF_W-1:0] nf;
        nf_plan = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd9, 4'd4};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, num_frames still at its reset value (total weight 8).
        // Fill every frame weight first so no merge reads an unwritten entry.
        weight_tile(3'd1, 16'd0, 16'd0, 1);          // zero diff -> clamp up, weight 7
        weight_tile(3'd2, 16'hFFFF, 16'd0, 5);       // sum >> 15 above 8 -> weight 0
        weight_tile(3'd5, 16'd0, 16'd32768, 2);      // alt above ref, weight 6
        weight_tile(3'd4, 16'd32767, 16'd0, 1);      // just under one step -> weight 7
        weight_tile(3'd6, 16'd57344, 16'd0, 4);      // seven steps -> weight 1
        weight_tile(3'd3, 16'hFFFF, 16'd0, 260);     // diff accumulator saturates
        weight_tile(3'd3, 16'd0, 16'd49152, 2);      // accumulator cleared -> weight 5
        weight_tile(3'd7, 16'hFFFF, 16'hFFFF, 1);    // full-scale equal pair, weight 7
        weight_tile(3'd0, 16'd1234, 16'd4321, 1);    // reference slot written too

        send_item(OP_MERGE, 3'd0, 16'hFFFF, 16'd0, 1'b1);     // reference only, full scale
        send_item(OP_MERGE, 3'd0, 16'd0, 16'hFFFF, 1'b1);     // reference only, zero
        send_item(OP_MERGE, 3'd2, 16'd500, 16'hFFFF, 1'b1);   // zero-weight alternate
        send_item(OP_MERGE, 3'd1, 16'd100, 16'd1000, 1'b0);   // weight sum exactly total
        send_item(OP_MERGE, 3'd6, 16'd100, 16'd2000, 1'b0);
        send_item(OP_MERGE, 3'd0, 16'd777, 16'd0, 1'b1);
        for (int p = 0; p < 3; p++)                           // weight sum above total
            send_item(OP_MERGE, 3'd7, 16'd9, 16'hFFFF, 1'b0);
        send_item(OP_MERGE, 3'd0, 16'hFFFF, 16'd0, 1'b1);
        for (int p = 0; p < 20; p++)                          // pixel and weight sums saturate,
            send_item(OP_MERGE, 3'd7, 16'hFFFF, 16'hFFFF, p == 19);  // result clips

        // Random phases, each under its own num_frames; the out-of-range
        // settings check the clamp on both ends.
        for (int ph = 0; ph < 8; ph++) begin
            nf = (ph < 6) ? nf_plan[ph] : NF_W'($urandom_range(0, 15));
            write_frames(nf);
            if (ph == 0) begin
                // receiver holds off while the sender keeps pushing
                hold_req <= hold_req + 1;
                random_traffic(PHASE_ITEMS);
            end else if (ph == 2) begin
                random_traffic(PHASE_ITEMS / 2);
                wait_drained();
                random_traffic(PHASE_ITEMS - PHASE_ITEMS / 2);
            end else begin
                random_traffic(PHASE_ITEMS);
            end
        end

        wait_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin : watchdog
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
